// ===== hdl/sgma_pkg.sv =====
// shared types, register indexes and arctangent constants for the sobel block
package sgma_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxRows    = 4096;
  localparam int unsigned SampleBits = 8;
  localparam int unsigned SumBits    = SampleBits + 2;
  localparam int unsigned ColBits    = $clog2(MaxWidth);
  localparam int unsigned RowBits    = $clog2(MaxRows);
  localparam int unsigned CordicSteps = 28;
  localparam int unsigned SqrtSteps   = 13;

  localparam logic [1:0] RegImageWidth   = 2'd0;
  localparam logic [1:0] RegImageHeight  = 2'd1;
  localparam logic [1:0] RegChannelsUsed = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_GRAD = 5'b00100,
    ST_CALC = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  typedef logic [SumBits-1:0] sample_t;

  // arctangent of 2^-i in units of pi/2^31
  function automatic logic [29:0] atan_unit(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/sobel_gradient_magnitude_angle.sv =====
// sobel gradient magnitude and angle over a raster pixel stream, one line memory
// Each accepted pixel passes through accept, then line memory read and write-back, then for
// every result it causes: the gradient sums and squares, 28 CORDIC iterations of which
// the first 13 also run square-root steps, a step that closes the iteration and one that
// loads the output register. A pixel causes up to four results (the last row of a frame
// is emitted alongside its predecessor); a new pixel is stalled until the last result is
// loaded into a free output register. Both line stores share one 1024 x 20 synchronous
// memory with a registered read. Results come out one row behind the input; configuration
// must be written only while idle, and the block itself does not enforce this.
module sobel_gradient_magnitude_angle
  import sgma_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [12:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           chan0_i,
  input  logic [7:0]           chan1_i,
  input  logic [7:0]           chan2_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [9:0]           out_col_o,
  output logic [11:0]          out_row_o,
  output logic [12:0]          magnitude_o,
  output logic signed [15:0]   angle_o,
  output logic                 last_in_run_o,
  output logic                 last_of_frame_o
);

  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [1:0]  chans_q;

  state_e state_q, state_d;

  logic [ColBits-1:0] x_q;
  logic [RowBits-1:0] y_q;
  sample_t s_q;
  sample_t cur_q [3];
  sample_t a_q [3];
  sample_t b_q [3];
  logic lastc_q, lastr_q;
  logic [1:0] job_q;

  logic [2*SumBits-1:0] line_mem [MaxWidth];
  logic [2*SumBits-1:0] rd_q;

  logic signed [12:0] gx_q, gy_q;
  logic [25:0] sq_q;
  logic signed [35:0] cx_q, cy_q;
  logic signed [33:0] cz_q;
  logic [4:0] cnt_q;
  logic [15:0] rem_q;
  logic [12:0] root_q;

  logic out_valid_q;
  logic [9:0] out_col_q;
  logic [11:0] out_row_q;
  logic [12:0] mag_q;
  logic signed [15:0] ang_q;
  logic lir_q, lof_q;

  logic accept, out_free;
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // sample sum
  sample_t sum;
  always_comb begin
    sum = SumBits'(chan0_i);
    if (chans_q >= 2'd2) sum = sum + SumBits'(chan1_i);
    if (chans_q == 2'd3) sum = sum + SumBits'(chan2_i);
  end

  logic [10:0] w_eff;
  logic [12:0] h_eff;
  always_comb begin
    w_eff = width_q;
    if (w_eff < 11'd1) w_eff = 11'd1;
    if (w_eff > 11'(MaxWidth)) w_eff = 11'(MaxWidth);
    h_eff = height_q;
    if (h_eff < 13'd1) h_eff = 13'd1;
    if (h_eff > 13'(MaxRows)) h_eff = 13'(MaxRows);
  end

  // pixel column as read back from the line memory
  sample_t cur_d [3];
  sample_t win_src [3];
  always_comb begin
    cur_d[0] = (y_q == '0) ? s_q : rd_q[2*SumBits-1:SumBits];
    cur_d[1] = (y_q == '0) ? s_q : rd_q[SumBits-1:0];
    cur_d[2] = s_q;
    for (int i = 0; i < 3; i++) begin
      win_src[i] = (state_q == ST_READ) ? cur_d[i] : cur_q[i];
    end
  end

  // result jobs: bit 1 picks the row pass, bit 0 the right-edge column
  logic [3:0] jv;
  logic [1:0] first_job, next_job;
  logic first_ok, next_ok;
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      jv[j] = (j[1] ? lastr_q : (y_q != '0)) && (j[0] ? lastc_q : (x_q != '0));
    end
    first_ok = 1'b0;
    first_job = 2'd0;
    next_ok = 1'b0;
    next_job = 2'd0;
    for (int j = 3; j >= 0; j--) begin
      if (jv[j]) begin
        first_ok = 1'b1;
        first_job = 2'(j);
      end
      if (jv[j] && (3'(j) > {1'b0, job_q})) begin
        next_ok = 1'b1;
        next_job = 2'(j);
      end
    end
  end

  // neighbourhood for the current job
  sample_t lc [3];
  sample_t cc [3];
  sample_t rc [3];
  logic [1:0] ti, mi, bi;
  logic [11:0] sr, sl, sb, st;
  logic signed [12:0] gx_d, gy_d;
  logic signed [25:0] gx_w, gy_w;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!job_q[0]) begin
        lc[i] = b_q[i];
        cc[i] = a_q[i];
      end else begin
        lc[i] = (x_q != '0) ? a_q[i] : cur_q[i];
        cc[i] = cur_q[i];
      end
      rc[i] = cur_q[i];
    end
    if (!job_q[1]) begin
      ti = 2'd0; mi = 2'd1; bi = 2'd2;
    end else begin
      ti = 2'd1; mi = 2'd2; bi = 2'd2;
    end
    sr = 12'(rc[ti]) + {1'b0, rc[mi], 1'b0} + 12'(rc[bi]);
    sl = 12'(lc[ti]) + {1'b0, lc[mi], 1'b0} + 12'(lc[bi]);
    sb = 12'(lc[bi]) + {1'b0, cc[bi], 1'b0} + 12'(rc[bi]);
    st = 12'(lc[ti]) + {1'b0, cc[ti], 1'b0} + 12'(rc[ti]);
    gx_d = $signed({1'b0, sr}) - $signed({1'b0, sl});
    gy_d = $signed({1'b0, sb}) - $signed({1'b0, st});
    gx_w = 26'(gx_d);
    gy_w = 26'(gy_d);
  end

  // one cordic and one square-root step
  logic signed [35:0] dx, dy;
  logic signed [33:0] zstep;
  logic [15:0] rem_sh, trial;
  logic [1:0] pair;
  always_comb begin
    dx = cy_q >>> cnt_q;
    dy = cx_q >>> cnt_q;
    zstep = $signed({4'b0, atan_unit(cnt_q)});
    pair = 2'(sq_q >> (5'd24 - {cnt_q[3:0], 1'b0}));
    rem_sh = {rem_q[13:0], pair};
    trial = {1'b0, root_q, 2'b01};
  end

  // quadrant restore and rounding
  logic signed [33:0] a_full;
  logic signed [33:0] r_full;
  logic signed [15:0] ang_d;
  logic [12:0] mag_d;
  always_comb begin
    if (!gx_q[12]) a_full = gy_q[12] ? -cz_q : cz_q;
    else a_full = gy_q[12] ? (cz_q - 34'sd2147483648) : (34'sd2147483648 - cz_q);
    r_full = (a_full + 34'sd32768) >>> 16;
    if (r_full > 34'sd32767) ang_d = 16'sh7fff;
    else if (r_full < -34'sd32768) ang_d = 16'sh8000;
    else ang_d = r_full[15:0];
    if (gx_q == '0 && gy_q == '0) ang_d = '0;
    mag_d = root_q + 13'((rem_q > 16'(root_q)) ? 1 : 0);
  end

  logic finish;
  always_comb begin
    state_d = state_q;
    finish = 1'b0;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_READ;
      ST_READ: begin
        if (first_ok) state_d = ST_GRAD;
        else begin
          state_d = ST_IDLE;
          finish = 1'b1;
        end
      end
      ST_GRAD: state_d = ST_CALC;
      ST_CALC: if (cnt_q == 5'(CordicSteps)) state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          if (next_ok) state_d = ST_GRAD;
          else begin
            state_d = ST_IDLE;
            finish = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // line memory: older row in the upper half, prior row in the lower
  always_ff @(posedge clk_i) begin
    rd_q <= line_mem[x_q];
  end
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      line_mem[x_q] <= {((y_q == '0) ? s_q : rd_q[SumBits-1:0]), s_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      width_q  <= 11'd640;
      height_q <= 13'd480;
      chans_q  <= 2'd3;
      x_q      <= '0;
      y_q      <= '0;
      for (int i = 0; i < 3; i++) begin
        a_q[i] <= '0;
        b_q[i] <= '0;
      end
      job_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegImageWidth:   width_q  <= cfg_data_i[10:0];
          RegImageHeight:  height_q <= cfg_data_i;
          RegChannelsUsed: chans_q  <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (state_q == ST_READ) job_q <= first_job;
      if (state_q == ST_EMIT && out_free) job_q <= next_job;
      if (finish) begin
        for (int i = 0; i < 3; i++) begin
          b_q[i] <= (x_q == '0) ? win_src[i] : a_q[i];
          a_q[i] <= win_src[i];
        end
        if (lastc_q) begin
          x_q <= '0;
          y_q <= lastr_q ? '0 : y_q + 1'b1;
        end else begin
          x_q <= x_q + 1'b1;
        end
      end
      if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q     <= sum;
      lastc_q <= ({1'b0, x_q} >= w_eff - 11'd1);
      lastr_q <= ({1'b0, y_q} >= h_eff - 13'd1);
    end
    if (state_q == ST_READ) begin
      for (int i = 0; i < 3; i++) begin
        cur_q[i] <= cur_d[i];
      end
    end
    if (state_q == ST_GRAD) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
      cnt_q <= '0;
      rem_q <= '0;
      root_q <= '0;
      cz_q <= '0;
      cx_q <= $signed({4'b0, (gx_d[12] ? 12'(-gx_d) : gx_d[11:0]), 20'b0});
      cy_q <= $signed({4'b0, (gy_d[12] ? 12'(-gy_d) : gy_d[11:0]), 20'b0});
      sq_q <= 26'(gx_w * gx_w) + 26'(gy_w * gy_w);
    end
    if (state_q == ST_CALC && cnt_q != 5'(CordicSteps)) begin
      cnt_q <= cnt_q + 1'b1;
      if (!cy_q[35]) begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        cz_q <= cz_q + zstep;
      end else begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        cz_q <= cz_q - zstep;
      end
      if (cnt_q < 5'(SqrtSteps)) begin
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[11:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[11:0], 1'b0};
        end
      end
    end
    if (state_q == ST_EMIT && out_free) begin
      out_col_q <= job_q[0] ? x_q : x_q - 1'b1;
      out_row_q <= job_q[1] ? y_q : y_q - 1'b1;
      mag_q     <= mag_d;
      ang_q     <= ang_d;
      lir_q     <= !next_ok;
      lof_q     <= !next_ok && lastc_q && lastr_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_col_o       = out_col_q;
  assign out_row_o       = out_row_q;
  assign magnitude_o     = mag_q;
  assign angle_o         = ang_q;
  assign last_in_run_o   = lir_q;
  assign last_of_frame_o = lof_q;

`ifndef ASSERT_OFF
  a_lof_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!last_of_frame_o || last_in_run_o))
    else $error("frame end without run end");
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_READ)
    else $error("accept not followed by memory read");
  a_calc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC |-> cnt_q <= 5'(CordicSteps))
    else $error("iteration count overrun");
  a_emit_after_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && $past(state_q) != ST_EMIT) |-> $past(state_q) == ST_CALC)
    else $error("result loaded without calculation");
`endif

endmodule
